/* design/ihw_pkg.sv */
// Shared constants, types and helper functions of the Intel HEX record writer.
`timescale 1ns / 1ps

package ihw_pkg;

   // Record buffer depth and the derived widths
   localparam int MAX_RECORD_BYTES = 16;
   localparam int OUT_LIMIT        = 55;   // most characters one transaction may cause
   localparam int EOF_CHARS        = 12;   // ":00000001FF\n"
   localparam int REC_OVERHEAD     = 12;   // ':', count, address, type, checksum, '\n'
   localparam int HDR_BYTES        = 4;    // count, address high, address low, type

   localparam int BUF_AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_RECORD_BYTES + 1);
   localparam int POS_W  = $clog2(REC_OVERHEAD + 2 * MAX_RECORD_BYTES);
   localparam int B_W    = POS_W - 1;
   localparam int OUT_W  = $clog2(OUT_LIMIT + 1);
   localparam int TOT_W  = $clog2(2 * EOF_CHARS + REC_OVERHEAD + 2 * MAX_RECORD_BYTES + 1);

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LENGTH = 1'd1;
   localparam logic [4:0] RECORD_LENGTH_RESET = 5'd16;

   // Characters and fixed record bytes
   localparam logic [6:0] CHAR_COLON       = 7'h3A;
   localparam logic [6:0] CHAR_NEWLINE     = 7'h0A;
   localparam logic [6:0] CHAR_ZERO        = 7'h30;
   localparam logic [6:0] CHAR_ALPHA_BASE  = 7'h37;  // 'A' minus ten
   localparam logic [7:0] REC_TYPE_DATA    = 8'h00;
   localparam logic [7:0] REC_TYPE_EOF     = 8'h01;
   localparam logic [7:0] EOF_CHECKSUM     = 8'hFF;
   localparam int         EOF_TYPE_IDX     = 3;
   localparam int         EOF_SUM_IDX      = 4;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // take the request transaction this cycle
      logic emit;      // load the next character into the output register
      logic seg_rec;   // current segment is a data record, else an EOF record
   } ihw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic new_pend;     // held EOF record goes out first
      logic new_rec;      // this transaction emits a data record
      logic new_any;      // this transaction emits at least one character
      logic rec_planned;  // latched: the transaction in progress has a data record
      logic seg_done;     // current character closes its record
      logic item_done;    // current character is the last of the transaction
      logic slot_free;    // output register can take a character
   } ihw_status_type;

   // Uppercase ASCII hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] n7;
      n7 = {3'b000, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + n7;
      end else begin
         return CHAR_ALPHA_BASE + n7;
      end
   endfunction

   // Bytes of the EOF record: 00 0000 01 FF
   function automatic logic [7:0] eof_byte(input logic [B_W-1:0] b);
      if (b == B_W'(EOF_TYPE_IDX)) begin
         return REC_TYPE_EOF;
      end else if (b == B_W'(EOF_SUM_IDX)) begin
         return EOF_CHECKSUM;
      end else begin
         return 8'h00;
      end
   endfunction

endpackage

/* design/ihw_datapath.sv */
// Datapath: registers, record buffer, transaction planning and character generation.
`timescale 1ns / 1ps

module ihw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [ihw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ihw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_carries_byte,
   input  logic                              req_end_of_image,
   input  ihw_pkg::ihw_cmd_type              cmd,
   output ihw_pkg::ihw_status_type           status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [6:0]                        rsp_out_char,
   output logic                              rsp_last_char
);

   // Configuration
   logic [15:0] base_address_ff;
   logic [4:0]  record_length_ff;

   // Image state
   logic [ihw_pkg::CNT_W-1:0] fill_ff;
   logic [15:0]               record_address_ff;
   logic                      image_started_ff;
   logic                      eof_pending_ff;
   logic [7:0]                record_buffer [ihw_pkg::MAX_RECORD_BYTES];

   // Plan of the transaction in progress
   logic                      rec_ff;
   logic [ihw_pkg::CNT_W-1:0] cnt_ff;
   logic [15:0]               emit_addr_ff;
   logic [ihw_pkg::OUT_W-1:0] total_ff;

   // Sequencing
   logic [ihw_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [ihw_pkg::OUT_W-1:0] count_ff;
   logic [7:0]                sum_ff;
   logic [7:0]                rd_ff;
   logic [ihw_pkg::BUF_AW-1:0] rd_addr;

   // Output register
   logic       rsp_valid_ff;
   logic [6:0] rsp_char_ff;
   logic       rsp_last_ff;

   // Planning signals
   logic [ihw_pkg::CNT_W-1:0] eff_len;
   logic                      has_room;
   logic [ihw_pkg::CNT_W-1:0] fill_after;
   logic                      new_rec;
   logic [ihw_pkg::TOT_W-1:0] rec_chars, pend_chars, pre_total, full_total;
   logic                      eof_fits;
   logic                      new_eof;
   logic [ihw_pkg::OUT_W-1:0] new_total;
   logic [15:0]               cur_addr;

   // Character generation signals
   logic [ihw_pkg::POS_W-1:0] pm1, pm1_next, seg_len_m1;
   logic [ihw_pkg::B_W-1:0]   b_idx, b_next, d_next, data_end_b;
   logic                      low_nib;
   logic                      seg_done;
   logic [7:0]                rec_byte, cur_byte;
   logic [3:0]                nib;
   logic [6:0]                char_now;

   // Effective record length, clamped to 1..MAX_RECORD_BYTES
   always_comb begin
      if (record_length_ff == 5'd0) begin
         eff_len = ihw_pkg::CNT_W'(1);
      end else if (int'(record_length_ff) > ihw_pkg::MAX_RECORD_BYTES) begin
         eff_len = ihw_pkg::CNT_W'(ihw_pkg::MAX_RECORD_BYTES);
      end else begin
         eff_len = ihw_pkg::CNT_W'(record_length_ff);
      end
   end

   // What the incoming transaction will emit
   always_comb begin
      has_room   = int'(fill_ff) < ihw_pkg::MAX_RECORD_BYTES;
      fill_after = (req_carries_byte && has_room) ? fill_ff + 1'b1 : fill_ff;
      new_rec    = (req_carries_byte && (fill_after >= eff_len)) ||
                   (req_end_of_image && (fill_after != '0));
      rec_chars  = new_rec ? ihw_pkg::TOT_W'(ihw_pkg::REC_OVERHEAD) +
                             (ihw_pkg::TOT_W'(fill_after) << 1) : '0;
      pend_chars = eof_pending_ff ? ihw_pkg::TOT_W'(ihw_pkg::EOF_CHARS) : '0;
      pre_total  = pend_chars + rec_chars;
      eof_fits   = pre_total <= ihw_pkg::TOT_W'(ihw_pkg::OUT_LIMIT - ihw_pkg::EOF_CHARS);
      new_eof    = req_end_of_image && eof_fits;
      full_total = pre_total + (new_eof ? ihw_pkg::TOT_W'(ihw_pkg::EOF_CHARS) : '0);
      if (full_total > ihw_pkg::TOT_W'(ihw_pkg::OUT_LIMIT)) begin
         new_total = ihw_pkg::OUT_W'(ihw_pkg::OUT_LIMIT);
      end else begin
         new_total = full_total[ihw_pkg::OUT_W-1:0];
      end
      cur_addr = (req_carries_byte && !image_started_ff) ? base_address_ff
                                                         : record_address_ff;
   end

   // Position decode of the current character
   always_comb begin
      pm1        = pos_ff - 1'b1;
      b_idx      = pm1[ihw_pkg::POS_W-1:1];
      low_nib    = !pos_ff[0];
      seg_len_m1 = cmd.seg_rec ?
                   ihw_pkg::POS_W'(ihw_pkg::REC_OVERHEAD - 1) + (ihw_pkg::POS_W'(cnt_ff) << 1) :
                   ihw_pkg::POS_W'(ihw_pkg::EOF_CHARS - 1);
      seg_done   = pos_ff == seg_len_m1;
      data_end_b = ihw_pkg::B_W'(ihw_pkg::HDR_BYTES) + ihw_pkg::B_W'(cnt_ff);
   end

   // Byte behind the current hex digit
   always_comb begin
      priority if (b_idx == ihw_pkg::B_W'(0)) begin
         rec_byte = 8'(cnt_ff);
      end else if (b_idx == ihw_pkg::B_W'(1)) begin
         rec_byte = emit_addr_ff[15:8];
      end else if (b_idx == ihw_pkg::B_W'(2)) begin
         rec_byte = emit_addr_ff[7:0];
      end else if (b_idx == ihw_pkg::B_W'(3)) begin
         rec_byte = ihw_pkg::REC_TYPE_DATA;
      end else if (b_idx < data_end_b) begin
         rec_byte = rd_ff;
      end else begin
         rec_byte = 8'h00 - sum_ff;   // two's-complement checksum
      end
      cur_byte = cmd.seg_rec ? rec_byte : ihw_pkg::eof_byte(b_idx);
      nib      = low_nib ? cur_byte[3:0] : cur_byte[7:4];
      priority if (pos_ff == '0) begin
         char_now = ihw_pkg::CHAR_COLON;
      end else if (seg_done) begin
         char_now = ihw_pkg::CHAR_NEWLINE;
      end else begin
         char_now = ihw_pkg::hex_char(nib);
      end
   end

   // Next position and the buffer entry it will need
   always_comb begin
      if (cmd.accept) begin
         pos_in = '0;
      end else if (cmd.emit) begin
         pos_in = seg_done ? '0 : pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
      pm1_next = pos_in - 1'b1;
      b_next   = pm1_next[ihw_pkg::POS_W-1:1];
      d_next   = b_next - ihw_pkg::B_W'(ihw_pkg::HDR_BYTES);
      if ((b_next >= ihw_pkg::B_W'(ihw_pkg::HDR_BYTES)) &&
          (int'(d_next) < ihw_pkg::MAX_RECORD_BYTES)) begin
         rd_addr = d_next[ihw_pkg::BUF_AW-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   // Record buffer: written on accept, read one character ahead
   always_ff @(posedge clock) begin
      if (cmd.accept && req_carries_byte && has_room) begin
         record_buffer[fill_ff[ihw_pkg::BUF_AW-1:0]] <= req_data_byte;
      end
      rd_ff <= record_buffer[rd_addr];
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         record_length_ff <= ihw_pkg::RECORD_LENGTH_RESET;
      end else if (csr_valid) begin
         if (csr_index == ihw_pkg::CSR_BASE_ADDRESS) begin
            base_address_ff <= csr_wdata;
         end
         if (csr_index == ihw_pkg::CSR_RECORD_LENGTH) begin
            record_length_ff <= csr_wdata[4:0];
         end
      end
   end

   // Image state and plan, updated per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff           <= '0;
         record_address_ff <= '0;
         image_started_ff  <= 1'b0;
         eof_pending_ff    <= 1'b0;
         rec_ff            <= 1'b0;
         total_ff          <= '0;
      end else if (cmd.accept) begin
         fill_ff           <= new_rec ? '0 : fill_after;
         record_address_ff <= new_rec ? cur_addr + 16'(fill_after) : cur_addr;
         image_started_ff  <= req_end_of_image ? 1'b0
                                               : (image_started_ff | req_carries_byte);
         eof_pending_ff    <= req_end_of_image && !eof_fits;
         rec_ff            <= new_rec;
         total_ff          <= new_total;
      end
   end

   // Plan payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cnt_ff       <= fill_after;
         emit_addr_ff <= cur_addr;
      end
   end

   // Position and character count
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         if (cmd.accept) begin
            count_ff <= '0;
         end else if (cmd.emit) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Checksum accumulates on the low digit of every header and data byte
   always_ff @(posedge clock) begin
      if (cmd.emit && cmd.seg_rec) begin
         if (pos_ff == '0) begin
            sum_ff <= 8'h00;
         end else if (low_nib && (b_idx < data_end_b)) begin
            sum_ff <= sum_ff + cur_byte;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff <= char_now;
         rsp_last_ff <= status.item_done;
      end
   end

   // Status to the controller
   always_comb begin
      status.new_pend    = eof_pending_ff;
      status.new_rec     = new_rec;
      status.new_any     = new_total != '0;
      status.rec_planned = rec_ff;
      status.seg_done    = seg_done;
      status.item_done   = count_ff == (total_ff - 1'b1);
      status.slot_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

/* design/ihw_control.sv */
// Controller: walks the held EOF, data record and EOF segments of one transaction.
`timescale 1ns / 1ps

module ihw_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ihw_pkg::ihw_status_type status,
   output ihw_pkg::ihw_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PEND = 4'b0010,
      ST_REC  = 4'b0100,
      ST_EOF  = 4'b1000
   } ihw_state_type;

   ihw_state_type state_ff, state_in;

   // Commands
   always_comb begin
      cmd.accept  = (state_ff == ST_IDLE) && req_valid;
      cmd.emit    = (state_ff != ST_IDLE) && status.slot_free;
      cmd.seg_rec = state_ff == ST_REC;
   end

   assign req_stall = state_ff != ST_IDLE;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.new_any) begin
               priority if (status.new_pend) begin
                  state_in = ST_PEND;
               end else if (status.new_rec) begin
                  state_in = ST_REC;
               end else begin
                  state_in = ST_EOF;
               end
            end
         end
         ST_PEND: begin
            if (cmd.emit) begin
               priority if (status.item_done) begin
                  state_in = ST_IDLE;
               end else if (status.seg_done) begin
                  state_in = status.rec_planned ? ST_REC : ST_EOF;
               end else begin
                  state_in = state_ff;
               end
            end
         end
         ST_REC: begin
            if (cmd.emit) begin
               priority if (status.item_done) begin
                  state_in = ST_IDLE;
               end else if (status.seg_done) begin
                  state_in = ST_EOF;
               end else begin
                  state_in = state_ff;
               end
            end
         end
         ST_EOF: begin
            if (cmd.emit && (status.item_done || status.seg_done)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/intel_hex_record_writer.sv */
// Top level of the Intel HEX record writer: controller plus datapath.
//
// Image bytes are collected into a record buffer; a buffer filled to the record
// length, or the end of the image, sends out one Intel HEX data record as ASCII
// text, one character per rsp transaction, and the end of the image adds the EOF
// record. A request transaction that causes text holds req_stall high while its
// characters leave at one per cycle through the single output register, unless
// rsp_stall holds it, and the next request is taken in the cycle after the last
// character is loaded. rsp_last_char marks the final character caused by a
// request transaction. If the text of an end (a held EOF record, the flushed data
// record and its own EOF record) would exceed 55 characters, its EOF record is
// held and goes out first with the next request transaction; a held EOF record
// followed by a full 16-byte record is cut at 55 characters, which drops the
// record's closing newline. Registers are written through the csr channel, always
// ready, and should only be written while the block is idle.
`timescale 1ns / 1ps

module intel_hex_record_writer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ihw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ihw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_carries_byte,
   input  logic                              req_end_of_image,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [6:0]                        rsp_out_char,
   output logic                              rsp_last_char
);

   ihw_pkg::ihw_cmd_type    cmd;
   ihw_pkg::ihw_status_type status;

   assign csr_ready = 1'b1;

   ihw_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ihw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_data_byte    (req_data_byte),
      .req_carries_byte (req_carries_byte),
      .req_end_of_image (req_end_of_image),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule

/* design/ihw_checker.sv */
// Port-level checks of the Intel HEX record writer, bound to the top level.
`timescale 1ns / 1ps

module ihw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   // A stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("stalled character changed");

   // While a non-final character waits, the transaction is still in progress
   a_busy_mid_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> req_stall)
      else $error("request side idle in the middle of a transaction's text");

   // A record start is never the final character
   a_colon_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_char == ihw_pkg::CHAR_COLON) |-> !rsp_last_char)
      else $error("record start flagged as last character");

   // The byte count digit follows an unstalled record start in the next cycle
   a_hex_after_colon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_out_char == ihw_pkg::CHAR_COLON) |=>
         rsp_valid && (((rsp_out_char >= 7'h30) && (rsp_out_char <= 7'h39)) ||
                       ((rsp_out_char >= 7'h41) && (rsp_out_char <= 7'h46))))
      else $error("no hex digit after record start");

endmodule

bind intel_hex_record_writer ihw_checker u_ihw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);
